### rtl/per_sensor_min_max_mean_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-sensor statistics block
// Implication checks on the block clock with the asynchronous reset masked.
// Defining NO_ASSERTIONS turns every check into nothing.
// ----------------------------------------------------------------------------
`ifndef PER_SENSOR_MIN_MAX_MEAN_DEFINES_SVH
`define PER_SENSOR_MIN_MAX_MEAN_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PSMM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PSMM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PSMM_ASSERT_IMP(label, ante, cons, msg)
`define PSMM_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### rtl/psmm_pkg.sv
// ----------------------------------------------------------------------------
// psmm_pkg
// Field widths and codes shared by the statistics block and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package psmm_pkg;

	// transaction field widths
	localparam int KIND_W = 1;
	localparam int ID_W   = 8;
	localparam int CONC_W = 16;
	localparam int TIME_W = 32;
	localparam int ROW_W  = 5;
	localparam int STAT_W = 2;
	localparam int VAL_W  = 20;
	localparam int CFG_W  = 5;

	// accumulator widths
	localparam int SUM_W  = 40;
	localparam int CNT_W  = 24;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b0;
	localparam logic [KIND_W-1:0] KIND_REPORT = 1'b1;

	// statistic codes of a report row
	localparam logic [STAT_W-1:0] STAT_MAX  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MIN  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MEAN = 2'd2;

	// saturated sample count
	localparam logic [CNT_W-1:0] COUNT_FULL = {CNT_W{1'b1}};

endpackage

`default_nettype wire

### rtl/psmm_in_if.sv
// ----------------------------------------------------------------------------
// psmm_in_if
// Input channel: sample updates and report requests, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface psmm_in_if import psmm_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   sensor_id;
	logic [CONC_W-1:0] concentration;
	logic [TIME_W-1:0] sample_time;

	modport source (
		output valid, kind, sensor_id, concentration, sample_time,
		input  ready
	);

	modport sink (
		input  valid, kind, sensor_id, concentration, sample_time,
		output ready
	);

endinterface

`default_nettype wire

### rtl/psmm_out_if.sv
// ----------------------------------------------------------------------------
// psmm_out_if
// Output channel: one report row per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface psmm_out_if import psmm_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  row_sensor;
	logic [STAT_W-1:0] statistic;
	logic [VAL_W-1:0]  stat_value;
	logic [TIME_W-1:0] stat_time;
	logic              has_data;
	logic              last_row;

	modport source (
		output valid, row_sensor, statistic, stat_value, stat_time, has_data, last_row,
		input  ready
	);

	modport sink (
		input  valid, row_sensor, statistic, stat_value, stat_time, has_data, last_row,
		output ready
	);

endinterface

`default_nettype wire

### rtl/per_sensor_min_max_mean.sv
// ----------------------------------------------------------------------------
// per_sensor_min_max_mean
// Per-sensor dust statistics: running max, min, sum and count per sensor,
// with a report that walks all sensors in use and emits max/min/mean rows.
// ----------------------------------------------------------------------------
// One item is handled at a time; req.ready is low while an item is in work.
// A sample is accepted, then gets one read-modify-write of its sensor's
// entry. A report is accepted, then for each sensor in use it loads the
// entry; a sensor with data then runs 46 steps of the shared restoring
// divider that forms the rounded mean; every sensor then gives its max, min
// and mean rows, held while the row sink stalls. A report with zero sensors
// in use ends after the load. The mean divider (one 26-bit subtract and
// compare per step) sets the report length. Rows leave through an output
// register, so a row waits there while the next sensor is being worked on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_sensor_min_max_mean_defines.svh"

module per_sensor_min_max_mean import psmm_pkg::*; #(
	parameter int MAX_SENSORS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	psmm_in_if.sink               req,
	psmm_out_if.source            rows
);

	localparam int IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int NUM_W   = SUM_W + 6;      // sum*20 + count
	localparam int DEN_W   = CNT_W + 1;      // count*2
	localparam int STEP_W  = $clog2(NUM_W + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UPD   = 3'd1;
	localparam logic [2:0] S_RLOAD = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_RMAX  = 3'd4;
	localparam logic [2:0] S_RMIN  = 3'd5;
	localparam logic [2:0] S_RMEAN = 3'd6;

	logic [2:0]        state_q;
	logic [CFG_W-1:0]  sensors_in_use_q;

	// per-sensor statistics
	logic [CONC_W-1:0] max_store [MAX_SENSORS];
	logic [CONC_W-1:0] min_store [MAX_SENSORS];
	logic [TIME_W-1:0] max_stamp [MAX_SENSORS];
	logic [TIME_W-1:0] min_stamp [MAX_SENSORS];
	logic [SUM_W-1:0]  sum_store [MAX_SENSORS];
	logic [CNT_W-1:0]  count_store [MAX_SENSORS];

	// latched sample
	logic [ID_W-1:0]   id_q;
	logic [CONC_W-1:0] conc_q;
	logic [TIME_W-1:0] time_q;

	// report walk and divider
	logic [IDX_W-1:0]  rpt_k_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;

	// output register
	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_has_q;
	logic              out_last_q;

	logic [CFG_W-1:0]  n_eff;
	logic              accept;
	logic              out_free;
	logic [ID_W-1:0]   id_m1;
	logic [IDX_W-1:0]  upd_k;
	logic              upd_ok;
	logic [ROW_W-1:0]  rpt_id;
	logic              rpt_last;
	logic              rpt_has;
	logic [CNT_W-1:0]  rpt_cnt;
	logic [SUM_W-1:0]  rpt_sum;
	logic [NUM_W-1:0]  num_load;
	logic [DEN_W:0]    trial;
	logic              trial_ge;
	logic [DEN_W:0]    trial_diff;
	logic [VAL_W-1:0]  max_x10;
	logic [VAL_W-1:0]  min_x10;

	// effective sensor count
	assign n_eff = (sensors_in_use_q > CFG_W'(MAX_SENSORS)) ?
		CFG_W'(MAX_SENSORS) : sensors_in_use_q;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rows.ready;

	// sample address and acceptance check
	assign id_m1  = id_q - ID_W'(1);
	assign upd_k  = id_m1[IDX_W-1:0];
	assign upd_ok = (id_q != '0) && (id_q <= ID_W'(n_eff)) &&
		(count_store[upd_k] != COUNT_FULL);

	// report entry view
	assign rpt_id   = ROW_W'(rpt_k_q) + ROW_W'(1);
	assign rpt_last = (rpt_id == n_eff);
	assign rpt_cnt  = count_store[rpt_k_q];
	assign rpt_sum  = sum_store[rpt_k_q];
	assign rpt_has  = (rpt_cnt != '0);
	assign max_x10  = (VAL_W'(max_store[rpt_k_q]) << 3) + (VAL_W'(max_store[rpt_k_q]) << 1);
	assign min_x10  = (VAL_W'(min_store[rpt_k_q]) << 3) + (VAL_W'(min_store[rpt_k_q]) << 1);

	// rounded-mean dividend: sum*20 + count
	assign num_load = (NUM_W'(rpt_sum) << 4) + (NUM_W'(rpt_sum) << 2) + NUM_W'(rpt_cnt);

	// one restoring division step
	assign trial      = {rem_q, quo_q[NUM_W-1]};
	assign trial_ge   = (trial >= {1'b0, den_q});
	assign trial_diff = trial - {1'b0, den_q};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensors_in_use_q <= CFG_W'(16);
		end else if (cfg_we) begin
			sensors_in_use_q <= cfg_wdata;
		end
	end

	// sample latch
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= req.sensor_id;
			conc_q <= req.concentration;
			time_q <= req.sample_time;
		end
	end

	// statistics read-modify-write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SENSORS; i++) begin
				max_store[i]   <= '0;
				min_store[i]   <= '0;
				max_stamp[i]   <= '0;
				min_stamp[i]   <= '0;
				sum_store[i]   <= '0;
				count_store[i] <= '0;
			end
		end else if (state_q == S_UPD && upd_ok) begin
			if (conc_q >= max_store[upd_k]) begin
				max_store[upd_k] <= conc_q;
				max_stamp[upd_k] <= time_q;
			end
			if (min_store[upd_k] == '0 || conc_q <= min_store[upd_k]) begin
				min_store[upd_k] <= conc_q;
				min_stamp[upd_k] <= time_q;
			end
			sum_store[upd_k]   <= sum_store[upd_k] + SUM_W'(conc_q);
			count_store[upd_k] <= count_store[upd_k] + CNT_W'(1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rpt_k_q <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rpt_k_q <= '0;
						state_q <= (req.kind == KIND_REPORT) ? S_RLOAD : S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				S_RLOAD: begin
					step_q <= '0;
					if (n_eff == '0) begin
						state_q <= S_IDLE;
					end else if (rpt_has) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_RMAX;
					end
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= S_RMAX;
					end
				end
				S_RMAX: begin
					if (out_free) begin
						state_q <= S_RMIN;
					end
				end
				S_RMIN: begin
					if (out_free) begin
						state_q <= S_RMEAN;
					end
				end
				S_RMEAN: begin
					if (out_free) begin
						if (rpt_last) begin
							state_q <= S_IDLE;
						end else begin
							rpt_k_q <= rpt_k_q + IDX_W'(1);
							state_q <= S_RLOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// mean divider datapath
	always_ff @(posedge clk) begin
		if (state_q == S_RLOAD) begin
			quo_q <= num_load;
			den_q <= {rpt_cnt, 1'b0};
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			quo_q <= {quo_q[NUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_RMAX) || (state_q == S_RMIN) ||
				(state_q == S_RMEAN);
		end
	end

	// output row payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_row_q <= rpt_id;
			out_has_q <= rpt_has;
			unique case (state_q)
				S_RMAX: begin
					out_stat_q <= STAT_MAX;
					out_val_q  <= max_x10;
					out_time_q <= max_stamp[rpt_k_q];
					out_last_q <= 1'b0;
				end
				S_RMIN: begin
					out_stat_q <= STAT_MIN;
					out_val_q  <= min_x10;
					out_time_q <= min_stamp[rpt_k_q];
					out_last_q <= 1'b0;
				end
				default: begin
					out_stat_q <= STAT_MEAN;
					out_val_q  <= rpt_has ? quo_q[VAL_W-1:0] : '0;
					out_time_q <= '0;
					out_last_q <= rpt_last;
				end
			endcase
		end
	end

	assign rows.valid      = out_valid_q;
	assign rows.row_sensor = out_row_q;
	assign rows.statistic  = out_stat_q;
	assign rows.stat_value = out_val_q;
	assign rows.stat_time  = out_time_q;
	assign rows.has_data   = out_has_q;
	assign rows.last_row   = out_last_q;

	// checks
	`PSMM_ASSERT_NXT(a_accept_busy, accept, state_q != S_IDLE, "accepted item left block idle")
	`PSMM_ASSERT_IMP(a_div_den, state_q == S_DIV, den_q != '0, "divide by zero count")
	`PSMM_ASSERT_IMP(a_div_step, state_q == S_DIV, step_q <= LAST_STEP, "divider overran")
	`PSMM_ASSERT_IMP(a_last_row, out_valid_q && out_last_q, (out_stat_q == STAT_MEAN) && (out_row_q == n_eff), "last row misplaced")

endmodule

`default_nettype wire
